/* hdl/mwma_pkg.sv */
`timescale 1ns / 1ps

package mwma_pkg;

  // longest window, also the depth of the delay line
  localparam int LONGEST_WINDOW = 60;
  localparam int WINDOW_COUNT   = 5;

  localparam int PRICE_W   = 32;
  localparam int VOL_W     = 40;
  localparam int CNT_W     = $clog2(LONGEST_WINDOW + 1);
  localparam int PTR_W     = $clog2(LONGEST_WINDOW);
  localparam int WIN_IDX_W = $clog2(WINDOW_COUNT);
  localparam int PSUM_W    = PRICE_W + CNT_W;
  localparam int VSUM_W    = VOL_W + CNT_W;
  localparam int HIST_W    = PRICE_W + VOL_W;

  // divider retires DIV_RADIX quotient bits per cycle
  localparam int DIV_RADIX = 8;
  localparam int DIV_STEPS = (VSUM_W + DIV_RADIX - 1) / DIV_RADIX;
  localparam int DIV_W     = DIV_STEPS * DIV_RADIX;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  localparam logic [WIN_IDX_W-1:0] LAST_WIN = WIN_IDX_W'(WINDOW_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_ACC,
    S_WRITE,
    S_DIV_START,
    S_DIV_WAIT,
    S_DONE
  } mwma_state_t;

  typedef struct packed {
    logic                 load_in;
    logic                 rd_win;
    logic                 acc_win;
    logic                 wr_hist;
    logic                 div_start;
    logic                 store_quot;
    logic                 load_out;
    logic [WIN_IDX_W-1:0] win;
  } mwma_cmd_t;

  typedef struct packed {
    logic div_done;
  } mwma_stat_t;

  // length of window k
  function automatic logic [CNT_W-1:0] win_len(input logic [WIN_IDX_W-1:0] k);
    logic [CNT_W-1:0] len;
    unique case (k)
      WIN_IDX_W'(0): len = CNT_W'(5);
      WIN_IDX_W'(1): len = CNT_W'(10);
      WIN_IDX_W'(2): len = CNT_W'(20);
      WIN_IDX_W'(3): len = CNT_W'(30);
      default:       len = CNT_W'(LONGEST_WINDOW);
    endcase
    return len;
  endfunction

endpackage

/* hdl/mwma_in_if.sv */
`timescale 1ns / 1ps

interface mwma_in_if;
  import mwma_pkg::*;

  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] close_price;
  logic [VOL_W-1:0]   trade_volume;
  logic               first_of_series;

  modport source (
    output valid, close_price, trade_volume, first_of_series,
    input  ready
  );

  modport sink (
    input  valid, close_price, trade_volume, first_of_series,
    output ready
  );
endinterface

/* hdl/mwma_out_if.sv */
`timescale 1ns / 1ps

interface mwma_out_if;
  import mwma_pkg::*;

  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] avg_close_5;
  logic [PRICE_W-1:0] avg_close_10;
  logic [PRICE_W-1:0] avg_close_20;
  logic [PRICE_W-1:0] avg_close_30;
  logic [PRICE_W-1:0] avg_close_60;
  logic [VOL_W-1:0]   avg_volume_5;
  logic [VOL_W-1:0]   avg_volume_10;
  logic [VOL_W-1:0]   avg_volume_20;
  logic [VOL_W-1:0]   avg_volume_30;
  logic [VOL_W-1:0]   avg_volume_60;

  modport source (
    output valid, avg_close_5, avg_close_10, avg_close_20, avg_close_30, avg_close_60,
           avg_volume_5, avg_volume_10, avg_volume_20, avg_volume_30, avg_volume_60,
    input  ready
  );

  modport sink (
    input  valid, avg_close_5, avg_close_10, avg_close_20, avg_close_30, avg_close_60,
           avg_volume_5, avg_volume_10, avg_volume_20, avg_volume_30, avg_volume_60,
    output ready
  );
endinterface

/* hdl/mwma_div.sv */
`timescale 1ns / 1ps

// two-lane restoring divider, shared divisor, DIV_RADIX bits per cycle
module mwma_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mwma_pkg::DIV_W-1:0] dividend_p,
  input  logic [mwma_pkg::DIV_W-1:0] dividend_v,
  input  logic [mwma_pkg::CNT_W-1:0] divisor,
  output logic                       done,
  output logic [mwma_pkg::DIV_W-1:0] quot_p,
  output logic [mwma_pkg::DIV_W-1:0] quot_v
);
  import mwma_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DIV_W-1:0]  dq_p;
  logic [DIV_W-1:0]  dq_v;
  logic [CNT_W:0]    rem_p;
  logic [CNT_W:0]    rem_v;
  logic [CNT_W-1:0]  dvs;

  logic [DIV_W-1:0]  dq_p_next;
  logic [DIV_W-1:0]  dq_v_next;
  logic [CNT_W:0]    rem_p_next;
  logic [CNT_W:0]    rem_v_next;

  always_comb begin
    logic [DIV_W-1:0] qp;
    logic [DIV_W-1:0] qv;
    logic [CNT_W:0]   rp;
    logic [CNT_W:0]   rv;
    qp = dq_p;
    qv = dq_v;
    rp = rem_p;
    rv = rem_v;
    for (int i = 0; i < DIV_RADIX; i++) begin
      rp = {rp[CNT_W-1:0], qp[DIV_W-1]};
      rv = {rv[CNT_W-1:0], qv[DIV_W-1]};
      qp = {qp[DIV_W-2:0], 1'b0};
      qv = {qv[DIV_W-2:0], 1'b0};
      if (rp >= {1'b0, dvs}) begin
        rp    = rp - {1'b0, dvs};
        qp[0] = 1'b1;
      end
      if (rv >= {1'b0, dvs}) begin
        rv    = rv - {1'b0, dvs};
        qv[0] = 1'b1;
      end
    end
    dq_p_next  = qp;
    dq_v_next  = qv;
    rem_p_next = rp;
    rem_v_next = rv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_p  <= dividend_p;
      dq_v  <= dividend_v;
      rem_p <= '0;
      rem_v <= '0;
      dvs   <= divisor;
    end else if (busy) begin
      dq_p  <= dq_p_next;
      dq_v  <= dq_v_next;
      rem_p <= rem_p_next;
      rem_v <= rem_v_next;
    end
  end

  assign quot_p = dq_p;
  assign quot_v = dq_v;
endmodule

/* hdl/mwma_datapath.sv */
`timescale 1ns / 1ps

module mwma_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  mwma_pkg::mwma_cmd_t          cmd,
  output mwma_pkg::mwma_stat_t         stat,
  input  logic [mwma_pkg::PRICE_W-1:0] close_price,
  input  logic [mwma_pkg::VOL_W-1:0]   trade_volume,
  input  logic                         first_of_series,
  output logic [mwma_pkg::PRICE_W-1:0] avg_close  [mwma_pkg::WINDOW_COUNT],
  output logic [mwma_pkg::VOL_W-1:0]   avg_volume [mwma_pkg::WINDOW_COUNT]
);
  import mwma_pkg::*;

  // delay line, price in the low bits
  logic [HIST_W-1:0]  hist [LONGEST_WINDOW];
  logic [HIST_W-1:0]  rd_data;
  logic [PTR_W-1:0]   rd_addr;

  logic [PRICE_W-1:0] price;
  logic [VOL_W-1:0]   volume;
  logic [PSUM_W-1:0]  psum [WINDOW_COUNT];
  logic [VSUM_W-1:0]  vsum [WINDOW_COUNT];
  logic [CNT_W-1:0]   bars_seen;
  logic [PTR_W-1:0]   wr_ptr;
  logic [PRICE_W-1:0] q_price  [WINDOW_COUNT];
  logic [VOL_W-1:0]   q_volume [WINDOW_COUNT];

  logic [CNT_W-1:0]   wlen;
  logic [CNT_W:0]     wp_ext;
  logic [CNT_W:0]     wl_ext;
  logic [CNT_W:0]     addr_full;
  logic               leaving;
  logic [PRICE_W-1:0] old_price;
  logic [VOL_W-1:0]   old_volume;
  logic [CNT_W-1:0]   divisor;
  logic [DIV_W-1:0]   quot_p;
  logic [DIV_W-1:0]   quot_v;
  logic               div_done;

  assign wlen   = win_len(cmd.win);
  assign wp_ext = (CNT_W + 1)'(wr_ptr);
  assign wl_ext = {1'b0, wlen};

  // slot of the bar that drops out of the window
  assign addr_full = (wp_ext >= wl_ext) ? wp_ext - wl_ext
                                        : wp_ext + (CNT_W + 1)'(LONGEST_WINDOW) - wl_ext;
  assign rd_addr   = addr_full[PTR_W-1:0];

  // only a full window has a bar to drop
  assign leaving    = (bars_seen >= wlen);
  assign old_price  = leaving ? rd_data[PRICE_W-1:0] : '0;
  assign old_volume = leaving ? rd_data[HIST_W-1:PRICE_W] : '0;

  assign divisor = (bars_seen < wlen) ? bars_seen : wlen;

  always_ff @(posedge clk) begin
    if (cmd.rd_win) begin
      rd_data <= hist[rd_addr];
    end
    if (cmd.wr_hist) begin
      hist[wr_ptr] <= {volume, price};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bars_seen <= '0;
      wr_ptr    <= '0;
      for (int k = 0; k < WINDOW_COUNT; k++) begin
        psum[k] <= '0;
        vsum[k] <= '0;
      end
    end else begin
      if (cmd.load_in && first_of_series) begin
        bars_seen <= '0;
        wr_ptr    <= '0;
        for (int k = 0; k < WINDOW_COUNT; k++) begin
          psum[k] <= '0;
          vsum[k] <= '0;
        end
      end
      if (cmd.acc_win) begin
        psum[cmd.win] <= psum[cmd.win] - PSUM_W'(old_price) + PSUM_W'(price);
        vsum[cmd.win] <= vsum[cmd.win] - VSUM_W'(old_volume) + VSUM_W'(volume);
      end
      if (cmd.wr_hist) begin
        wr_ptr <= (wr_ptr == PTR_W'(LONGEST_WINDOW - 1)) ? '0 : wr_ptr + PTR_W'(1);
        if (bars_seen < CNT_W'(LONGEST_WINDOW)) begin
          bars_seen <= bars_seen + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      price  <= close_price;
      volume <= trade_volume;
    end
    if (cmd.store_quot) begin
      q_price[cmd.win]  <= quot_p[PRICE_W-1:0];
      q_volume[cmd.win] <= quot_v[VOL_W-1:0];
    end
    if (cmd.load_out) begin
      avg_close  <= q_price;
      avg_volume <= q_volume;
    end
  end

  mwma_div u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (cmd.div_start),
    .dividend_p (DIV_W'(psum[cmd.win])),
    .dividend_v (DIV_W'(vsum[cmd.win])),
    .divisor    (divisor),
    .done       (div_done),
    .quot_p     (quot_p),
    .quot_v     (quot_v)
  );

  assign stat.div_done = div_done;
endmodule

/* hdl/mwma_ctrl.sv */
`timescale 1ns / 1ps

module mwma_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  mwma_pkg::mwma_stat_t stat,
  output mwma_pkg::mwma_cmd_t  cmd
);
  import mwma_pkg::*;

  mwma_state_t          state;
  mwma_state_t          state_next;
  logic [WIN_IDX_W-1:0] win;
  logic [WIN_IDX_W-1:0] win_next;
  logic                 out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      win       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      win       <= win_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    win_next   = win;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.win    = win;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          win_next    = '0;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_win = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc_win = 1'b1;
        if (win == LAST_WIN) begin
          win_next   = '0;
          state_next = S_WRITE;
        end else begin
          win_next   = win + WIN_IDX_W'(1);
          state_next = S_READ;
        end
      end
      S_WRITE: begin
        cmd.wr_hist = 1'b1;
        state_next  = S_DIV_START;
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.store_quot = 1'b1;
          if (win == LAST_WIN) begin
            state_next = S_DONE;
          end else begin
            win_next   = win + WIN_IDX_W'(1);
            state_next = S_DIV_START;
          end
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end
endmodule

/* hdl/multi_window_moving_average_core.sv */
`timescale 1ns / 1ps
// per accepted bar: for each window a delay-line read and a sum update, then one history write,
// then for each window a run of the shared divider (8 quotient bits per cycle, 6 steps here);
// a new bar is taken only once the previous bar's results sit in the output register
// the output register lets the next bar be taken while a result waits downstream
// reset (rst, synchronous, active high) empties the window sums, bar count and write slot

module multi_window_moving_average_core (
  input logic        clk,
  input logic        rst,
  mwma_in_if.sink    bars,
  mwma_out_if.source avgs
);
  import mwma_pkg::*;

  // command and status between sequencer and datapath
  mwma_cmd_t          cmd;
  mwma_stat_t         stat;

  // result register, one entry per window, shortest first
  logic [PRICE_W-1:0] avg_close  [WINDOW_COUNT];
  logic [VOL_W-1:0]   avg_volume [WINDOW_COUNT];

  // sequencer: per bar it walks the windows twice, once to update the running
  // sums from the delay line, once to run the divider on each sum
  mwma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (bars.valid),
    .in_ready  (bars.ready),
    .out_valid (avgs.valid),
    .out_ready (avgs.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: delay line memory, running sums, bar count, divider and result register
  mwma_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .close_price     (bars.close_price),
    .trade_volume    (bars.trade_volume),
    .first_of_series (bars.first_of_series),
    .avg_close       (avg_close),
    .avg_volume      (avg_volume)
  );

  // windows in order 5, 10, 20, 30 and the longest
  assign avgs.avg_close_5   = avg_close[0];
  assign avgs.avg_close_10  = avg_close[1];
  assign avgs.avg_close_20  = avg_close[2];
  assign avgs.avg_close_30  = avg_close[3];
  assign avgs.avg_close_60  = avg_close[4];
  assign avgs.avg_volume_5  = avg_volume[0];
  assign avgs.avg_volume_10 = avg_volume[1];
  assign avgs.avg_volume_20 = avg_volume[2];
  assign avgs.avg_volume_30 = avg_volume[3];
  assign avgs.avg_volume_60 = avg_volume[4];
endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
  import mwma_pkg::*;

  // window lengths, shortest first, matching the order of the result fields
  localparam int WIN_LEN [WINDOW_COUNT] = '{5, 10, 20, 30, LONGEST_WINDOW};

  localparam int RANDOM_BARS = 600;
  // room for the processing of every bar plus worst sender gap and receiver stall,
  // several times over
  localparam int CYCLE_LIMIT = 600000;
  // settle time after the last result, a bit above the block latency
  localparam int SETTLE_CYCLES = 60;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [VOL_W-1:0]   volume;
    logic               series_start;
    logic               hold_for_drain;  // sender waits for all results first
  } bar_t;

  typedef struct {
    logic [PRICE_W-1:0] close  [WINDOW_COUNT];
    logic [VOL_W-1:0]   volume [WINDOW_COUNT];
  } avg_set_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mwma_in_if  bars ();
  mwma_out_if avgs ();

  multi_window_moving_average_core dut (
    .clk  (clk),
    .rst  (rst),
    .bars (bars),
    .avgs (avgs)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // bars waiting to be offered and averages waiting to come out
  bar_t     pending_bars [$];
  avg_set_t expected_avgs [$];

  int mismatches = 0;
  int cycle_count = 0;

  // ---------------------------------------------------------------------------
  // running-sum predictor: own copy of the delay lines, sums, count and slot
  // ---------------------------------------------------------------------------
  logic [PRICE_W-1:0] price_line  [LONGEST_WINDOW];
  logic [VOL_W-1:0]   volume_line [LONGEST_WINDOW];
  logic [PSUM_W-1:0]  price_sum   [WINDOW_COUNT];
  logic [VSUM_W-1:0]  volume_sum  [WINDOW_COUNT];
  int unsigned        bars_held;
  int unsigned        next_slot;

  initial begin
    for (int k = 0; k < WINDOW_COUNT; k++) begin
      price_sum[k]  = '0;
      volume_sum[k] = '0;
    end
    bars_held = 0;
    next_slot = 0;
  end

  // takes one bar in and queues the averages it should produce
  task automatic update_averages(input bar_t b);
    avg_set_t    res;
    int unsigned back;
    int unsigned n;
    // series start wipes sums, count and write slot before the bar goes in
    if (b.series_start) begin
      for (int k = 0; k < WINDOW_COUNT; k++) begin
        price_sum[k]  = '0;
        volume_sum[k] = '0;
      end
      bars_held = 0;
      next_slot = 0;
    end
    // leaving entry is only read once the window is full, and before the
    // slot is overwritten (matters for the longest window)
    for (int k = 0; k < WINDOW_COUNT; k++) begin
      if (bars_held >= WIN_LEN[k]) begin
        back = (next_slot + LONGEST_WINDOW - WIN_LEN[k]) % LONGEST_WINDOW;
        price_sum[k]  = price_sum[k] - price_line[back];
        volume_sum[k] = volume_sum[k] - volume_line[back];
      end
      price_sum[k]  = price_sum[k] + b.price;
      volume_sum[k] = volume_sum[k] + b.volume;
    end
    price_line[next_slot]  = b.price;
    volume_line[next_slot] = b.volume;
    next_slot = (next_slot + 1) % LONGEST_WINDOW;
    if (bars_held < LONGEST_WINDOW) bars_held++;
    // short series divide by the bars seen so far, current bar included
    for (int k = 0; k < WINDOW_COUNT; k++) begin
      n = (bars_held < WIN_LEN[k]) ? bars_held : WIN_LEN[k];
      if (n == 0) n = 1;
      res.close[k]  = PRICE_W'(price_sum[k] / n);
      res.volume[k] = VOL_W'(volume_sum[k] / n);
    end
    expected_avgs.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // bar driver: bursts of items with random gaps between them
  // ---------------------------------------------------------------------------
  bar_t current_bar;
  int   gap_left   = 0;
  int   burst_left = 1;

  always @(posedge clk) begin
    logic next_valid;
    next_valid = bars.valid;
    if (rst) begin
      next_valid = 1'b0;
      gap_left   = 0;
      burst_left = 1;
    end else begin
      // item taken at this edge: predict it now
      if (bars.valid && bars.ready) begin
        update_averages(current_bar);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_bars.size() > 0 &&
                     !(pending_bars[0].hold_for_drain && expected_avgs.size() > 0)) begin
          current_bar = pending_bars.pop_front();
          bars.close_price     <= current_bar.price;
          bars.trade_volume    <= current_bar.volume;
          bars.first_of_series <= current_bar.series_start;
          next_valid = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(40, 1);
            // a quarter of the bursts run straight into the next one
            gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(80, 1);
          end
        end
      end
    end
    bars.valid <= next_valid;
  end

  // ---------------------------------------------------------------------------
  // result receiver: runs of ready and of stall, each picked at random and of random length
  // ---------------------------------------------------------------------------
  int  run_left    = 0;
  logic ready_level = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      run_left    = 0;
      ready_level = 1'b0;
    end else if (run_left > 0) begin
      run_left--;
    end else begin
      ready_level = ($urandom_range(9, 0) < 6);
      if (ready_level) run_left = $urandom_range(120, 1);
      else if ($urandom_range(4, 0) == 0) run_left = $urandom_range(60, 20);
      else run_left = $urandom_range(8, 0);
    end
    avgs.ready <= ready_level;
  end

  // ---------------------------------------------------------------------------
  // monitor: every taken result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    avg_set_t seen;
    avg_set_t want;
    if (!rst && avgs.valid && avgs.ready) begin
      seen.close[0]  = avgs.avg_close_5;
      seen.close[1]  = avgs.avg_close_10;
      seen.close[2]  = avgs.avg_close_20;
      seen.close[3]  = avgs.avg_close_30;
      seen.close[4]  = avgs.avg_close_60;
      seen.volume[0] = avgs.avg_volume_5;
      seen.volume[1] = avgs.avg_volume_10;
      seen.volume[2] = avgs.avg_volume_20;
      seen.volume[3] = avgs.avg_volume_30;
      seen.volume[4] = avgs.avg_volume_60;
      if (expected_avgs.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result item, close_5 %h volume_5 %h",
                 $time, seen.close[0], seen.volume[0]);
      end else begin
        want = expected_avgs.pop_front();
        for (int k = 0; k < WINDOW_COUNT; k++) begin
          if (seen.close[k] !== want.close[k]) begin
            mismatches++;
            $display("%0t: avg_close_%0d expected %h actual %h",
                     $time, WIN_LEN[k], want.close[k], seen.close[k]);
          end
          if (seen.volume[k] !== want.volume[k]) begin
            mismatches++;
            $display("%0t: avg_volume_%0d expected %h actual %h",
                     $time, WIN_LEN[k], want.volume[k], seen.volume[k]);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_avgs.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  task automatic add_bar(input logic [PRICE_W-1:0] p, input logic [VOL_W-1:0] v,
                         input logic start, input logic drain);
    bar_t b;
    b.price          = p;
    b.volume         = v;
    b.series_start   = start;
    b.hold_for_drain = drain;
    pending_bars.push_back(b);
  endtask

  initial begin
    int made;
    int series_len;
    logic [PRICE_W-1:0] p;
    logic [VOL_W-1:0]   v;
    logic start;
    // known values on every input before the first edge
    bars.valid           = 1'b0;
    bars.close_price     = '0;
    bars.trade_volume    = '0;
    bars.first_of_series = 1'b0;
    avgs.ready           = 1'b0;

    // directed part
    // first bar straight after reset, without a series start
    add_bar('1, '1, 1'b0, 1'b0);
    // all-ones bars fill the short window with the largest input values
    for (int i = 0; i < 6; i++) add_bar('1, '1, 1'b0, 1'b0);
    // zeros drain the short window back down
    for (int i = 0; i < 5; i++) add_bar('0, '0, 1'b0, 1'b0);
    // series start in the middle of a stream, then two starts in a row
    add_bar(PRICE_W'(1), VOL_W'(1), 1'b1, 1'b0);
    add_bar('0, '0, 1'b1, 1'b0);
    add_bar('1, '1, 1'b1, 1'b0);
    // alternating bit patterns hit every bit both ways
    add_bar(32'hAAAA_AAAA, 40'hAA_AAAA_AAAA, 1'b0, 1'b0);
    add_bar(32'h5555_5555, 40'h55_5555_5555, 1'b0, 1'b0);
    add_bar(32'h8000_0000, 40'h80_0000_0000, 1'b0, 1'b0);
    add_bar(PRICE_W'(3), VOL_W'(7), 1'b0, 1'b0);
    // single-bar series with extreme values, result waited out first
    add_bar('1, '0, 1'b1, 1'b1);
    add_bar('0, '1, 1'b1, 1'b0);

    // random part: mostly long series that wrap the delay line, some short
    made = 0;
    while (made < RANDOM_BARS) begin
      if ($urandom_range(9, 0) < 7) series_len = $urandom_range(200, 61);
      else series_len = $urandom_range(12, 1);
      for (int i = 0; i < series_len && made < RANDOM_BARS; i++) begin
        case ($urandom_range(9, 0))
          0:       p = '1;
          1:       p = '0;
          2:       p = PRICE_W'($urandom_range(20, 0));
          default: p = PRICE_W'($urandom);
        endcase
        case ($urandom_range(9, 0))
          0:       v = '1;
          1:       v = '0;
          2:       v = VOL_W'($urandom_range(20, 0));
          default: v = {8'($urandom_range(255, 0)), 32'($urandom)};
        endcase
        // stray series starts break a series now and then
        start = (i == 0) || ($urandom_range(199, 0) == 0);
        add_bar(p, v, start, (made == 0) || ($urandom_range(149, 0) == 0));
        made++;
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // every bar taken, every result back, then a settle window
    while (pending_bars.size() != 0 || bars.valid) @(posedge clk);
    while (expected_avgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_avgs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_avgs.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
